// ----- hdl/fqmd_pkg.sv -----
// shared types and constants for the match-delete queue
package fqmd_pkg;

    localparam int unsigned DefQueueDepth = 16;
    localparam int unsigned ResultLimit   = 16;
    localparam logic [31:0] MinusOneWord  = 32'hBF80_0000;

    localparam logic [2:0] ACT_PUSH      = 3'd0;
    localparam logic [2:0] ACT_POP       = 3'd1;
    localparam logic [2:0] ACT_REM_KEY   = 3'd2;
    localparam logic [2:0] ACT_REM_TOPIC = 3'd3;
    localparam logic [2:0] ACT_UPD_KEY   = 3'd4;
    localparam logic [2:0] ACT_GROUP     = 3'd5;

    // one queue entry
    typedef struct packed {
        logic [31:0] key;
        logic [3:0]  topic;
        logic [31:0] question;
        logic [15:0] ticket;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic        shift_en;   // remove-style step: cells may take from their neighbor
        logic        write_en;   // push: tail cell loads new entry
        logic        upd_en;     // update: first key match rewrites topic and question
        logic [31:0] key;
        logic [3:0]  topic;
        logic [31:0] question;
        logic [15:0] ticket;
    } t_cmd;

endpackage

// ----- hdl/fifo_queue_with_match_delete.sv -----
// top level: chain of queue cells with a sequencer for commands and results
// Each item is decoded in the execute state against the whole row of cells, and its
// result item is registered; push, pop, remove by key and update give one result item.
// Remove by topic deletes one matching entry per cycle while the output is not stalled
// (the row closes one gap a cycle), then gives one result item. Group sends one result
// item per cycle while the output accepts, one per match up to sixteen. The next item is
// taken only after the last result item of the previous one has left.
// A stalled output holds the sequencer in place.
module fifo_queue_with_match_delete #(
    parameter int unsigned QUEUE_DEPTH = fqmd_pkg::DefQueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] action, [34:3] student_key, [38:35] topic_code, [70:39] question_word
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] status, [32:1] entry_key, [48:33] entry_ticket, [53:49] match_index,
    // [58:54] occupancy, [59] completed
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import fqmd_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]  r_state;
    logic [2:0]  r_act;
    logic [31:0] r_key, r_q;
    logic [3:0]  r_topic;
    logic [CW-1:0] r_fill;
    logic [15:0] r_visited;
    logic        r_done;
    logic        r_any;      // remove-by-topic found something
    logic [QUEUE_DEPTH-1:0] r_gmask; // group: matches still to send
    logic [4:0]  r_gcnt;
    logic        r_ovld;
    logic [63:0] r_odata;
    logic        r_olast;

    t_cmd   w_cmd;
    t_entry w_ent [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_occ, w_khit, w_thit, w_kfirst, w_take;
    logic        w_kany, w_tany;
    logic [IW-1:0] w_kpos, w_tpos, w_gpos;
    logic [QUEUE_DEPTH-1:0] w_gm, w_gfirst;
    logic        w_gany;

    // first-match priority over the row
    always_comb begin
        w_kfirst = '0; w_gfirst = '0;
        w_kany = 1'b0; w_tany = 1'b0; w_gany = 1'b0;
        w_kpos = '0; w_tpos = '0; w_gpos = '0;
        w_gm = (r_state == ST_OUT) ? r_gmask : w_thit;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_occ[i] = (CW'(i) < r_fill);
            if (w_khit[i] && !w_kany) begin
                w_kfirst[i] = 1'b1; w_kany = 1'b1; w_kpos = IW'(i);
            end
            if (w_thit[i] && !w_tany) begin
                w_tany = 1'b1; w_tpos = IW'(i);
            end
            if (w_gm[i] && !w_gany) begin
                w_gfirst[i] = 1'b1; w_gany = 1'b1; w_gpos = IW'(i);
            end
        end
    end

    // cells at or after the removed slot take from their neighbor
    logic [IW-1:0] w_rpos;
    logic          w_rem;
    always_comb begin
        w_rem  = 1'b0;
        w_rpos = '0;
        if (r_state == ST_EXEC) begin
            case (r_act)
                ACT_POP:       begin w_rem = (r_fill != '0); w_rpos = '0; end
                ACT_REM_KEY:   begin w_rem = w_kany; w_rpos = w_kpos; end
                ACT_REM_TOPIC: begin w_rem = w_tany; w_rpos = w_tpos; end
                default:       ;
            endcase
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_take[i] = w_rem && (IW'(i) >= w_rpos);
        end
    end

    assign w_cmd.shift_en = w_rem;
    assign w_cmd.write_en = (r_state == ST_EXEC) && (r_act == ACT_PUSH)
                            && (r_q != MinusOneWord) && (r_fill < CW'(QUEUE_DEPTH));
    assign w_cmd.upd_en   = (r_state == ST_EXEC) && (r_act == ACT_UPD_KEY);
    assign w_cmd.key      = r_key;
    assign w_cmd.topic    = r_topic;
    assign w_cmd.question = r_q;
    assign w_cmd.ticket   = r_visited + 16'(r_fill);

    // row of cells, each fed by its upper neighbor (the last one by itself)
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_nx;
        if (g == QUEUE_DEPTH - 1) begin : g_end
            assign w_nx = w_ent[g];
        end else begin : g_mid
            assign w_nx = w_ent[g+1];
        end
        fqmd_cell u_cell (
            .i_clk      (i_clk),
            .i_occ      (w_occ[g]),
            .i_is_tail  (CW'(g) == r_fill),
            .i_take     (w_take[g]),
            .i_first_key(w_kfirst[g]),
            .i_cmd      (w_cmd),
            .i_next     (w_nx),
            .o_entry    (w_ent[g]),
            .o_key_hit  (w_khit[g]),
            .o_tq_hit   (w_thit[g])
        );
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovld;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    wire w_ofree = !r_ovld || m_axis_tready;
    // execute step that stays busy instead of producing a result
    wire w_stay  = ((r_act == ACT_REM_TOPIC) && w_rem) || ((r_act == ACT_GROUP) && w_tany);
    // a new result item is loaded this cycle
    wire w_oset  = w_ofree && ((r_state == ST_OUT) || ((r_state == ST_EXEC) && !w_stay));

    // result word packer
    function automatic logic [63:0] pack(input logic st, input logic [31:0] k,
                                         input logic [15:0] t, input logic [4:0] ix,
                                         input logic [4:0] oc, input logic dn);
        pack = {4'd0, dn, oc, ix, t, k, st};
    endfunction

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill <= '0; r_visited <= '0; r_done <= 1'b0;
            r_ovld <= 1'b0; r_any <= 1'b0;
        end else begin
            if (r_ovld && m_axis_tready && !w_oset) r_ovld <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_act   <= s_axis_tdata[2:0];
                        r_key   <= s_axis_tdata[34:3];
                        r_topic <= s_axis_tdata[38:35];
                        r_q     <= s_axis_tdata[70:39];
                        r_any   <= 1'b0;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_ofree) begin
                        r_olast <= 1'b1;
                        if (!w_stay) r_state <= ST_IDLE;
                        case (r_act) inside
                            ACT_PUSH: begin
                                if (w_cmd.write_en) begin
                                    r_fill <= r_fill + 1'b1;
                                    r_done <= (r_visited == 16'(QUEUE_DEPTH));
                                    r_odata <= pack(1'b0, '0, '0, '0,
                                        5'(r_fill + 1'b1),
                                        r_visited == 16'(QUEUE_DEPTH));
                                end else begin
                                    r_odata <= pack(1'b1, '0, '0, '0, 5'(r_fill), r_done);
                                end
                                r_ovld <= 1'b1;
                            end
                            ACT_POP, ACT_REM_KEY: begin
                                if (w_rem) begin
                                    r_fill <= r_fill - 1'b1;
                                    r_visited <= r_visited + 1'b1;
                                    if (r_act == ACT_POP) begin
                                        r_done <= (r_fill == CW'(1));
                                        r_odata <= pack(1'b0, '0, '0, '0,
                                            5'(r_fill - 1'b1), r_fill == CW'(1));
                                    end else begin
                                        r_done <= (r_visited + 1'b1 == 16'(QUEUE_DEPTH));
                                        r_odata <= pack(1'b0, '0, '0, '0,
                                            5'(r_fill - 1'b1),
                                            r_visited + 1'b1 == 16'(QUEUE_DEPTH));
                                    end
                                end else begin
                                    r_odata <= pack(1'b1, '0, '0, '0, 5'(r_fill), r_done);
                                end
                                r_ovld <= 1'b1;
                            end
                            ACT_REM_TOPIC: begin
                                if (w_rem) begin
                                    // one removal per cycle while the output is not stalled, until no match remains
                                    r_fill <= r_fill - 1'b1;
                                    r_visited <= r_visited + 1'b1;
                                    r_any <= 1'b1;
                                    r_state <= ST_EXEC;
                                end else begin
                                    if (r_any) r_done <= (r_visited == 16'(QUEUE_DEPTH));
                                    r_odata <= pack(!r_any, '0, '0, '0, 5'(r_fill),
                                        r_any ? (r_visited == 16'(QUEUE_DEPTH)) : r_done);
                                    r_ovld <= 1'b1;
                                end
                            end
                            ACT_UPD_KEY: begin
                                r_odata <= pack(!w_kany, '0, '0, '0, 5'(r_fill), r_done);
                                r_ovld <= 1'b1;
                            end
                            ACT_GROUP: begin
                                if (w_tany) begin
                                    r_gmask <= w_thit;
                                    r_gcnt  <= '0;
                                    r_state <= ST_OUT;
                                end else begin
                                    r_odata <= pack(1'b1, '0, '0, '0, 5'(r_fill), r_done);
                                    r_ovld <= 1'b1;
                                end
                            end
                            default: begin
                                r_odata <= pack(1'b1, '0, '0, '0, 5'(r_fill), r_done);
                                r_ovld <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_OUT: begin
                    // one group result per cycle while the output accepts, lowest pending match first
                    if (w_ofree) begin
                        automatic logic lst;
                        lst = ((r_gmask & ~w_gfirst) == '0)
                              || (r_gcnt == 5'(ResultLimit - 1));
                        r_odata <= pack(1'b0, w_ent[w_gpos].key, w_ent[w_gpos].ticket,
                                        5'(w_gpos), 5'(r_fill), r_done);
                        r_olast <= lst;
                        r_ovld  <= 1'b1;
                        r_gmask <= r_gmask & ~w_gfirst;
                        r_gcnt  <= r_gcnt + 1'b1;
                        if (lst) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/fqmd_cell.sv -----
// one queue slot: holds an entry and compares it against the broadcast command
module fqmd_cell (
    input  logic            i_clk,
    input  logic            i_occ,       // this slot holds a live entry
    input  logic            i_is_tail,   // this slot is the first free one
    input  logic            i_take,      // load the entry from the next cell
    input  logic            i_first_key, // first key match in the row
    input  fqmd_pkg::t_cmd  i_cmd,
    input  fqmd_pkg::t_entry i_next,
    output fqmd_pkg::t_entry o_entry,
    output logic            o_key_hit,
    output logic            o_tq_hit
);
    import fqmd_pkg::*;

    t_entry r_entry;

    // compare against the broadcast fields
    assign o_key_hit = i_occ && (r_entry.key == i_cmd.key);
    assign o_tq_hit  = i_occ && (r_entry.topic == i_cmd.topic)
                             && (r_entry.question == i_cmd.question);
    assign o_entry   = r_entry;

    // load from neighbor, from the push port, or rewrite in place
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en && i_take) begin
            r_entry <= i_next;
        end else if (i_cmd.write_en && i_is_tail) begin
            r_entry <= '{key: i_cmd.key, topic: i_cmd.topic,
                         question: i_cmd.question, ticket: i_cmd.ticket};
        end else if (i_cmd.upd_en && i_first_key) begin
            r_entry.topic    <= i_cmd.topic;
            r_entry.question <= i_cmd.question;
        end
    end
endmodule

// ----- test/fqmd_checker.sv -----
// checker for the match-delete queue: predicts result items and compares them
`timescale 1ns / 1ps

module fqmd_checker
    import fqmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_out_data,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_group_hits
);

    localparam int Depth = DefQueueDepth;

    typedef struct packed {
        logic [59:0] data;
        logic        last;
    } t_result;

    // shadow queue state
    logic [31:0] q_key [Depth];
    logic [3:0]  q_topic [Depth];
    logic [31:0] q_question [Depth];
    logic [15:0] q_ticket [Depth];
    int          q_fill;
    logic [15:0] q_visited;
    logic        q_done;

    t_result     expected_results[$];

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic t_result make_result(input logic fail, input logic [31:0] key,
                                            input logic [15:0] ticket, input int idx,
                                            input logic last);
        t_result r;
        r.data = {q_done, 5'(q_fill), 5'(idx), ticket, key, fail};
        r.last = last;
        return r;
    endfunction

    task automatic drop_entry(input int pos);
        for (int j = pos; j + 1 < q_fill; j++) begin
            q_key[j] = q_key[j+1];
            q_topic[j] = q_topic[j+1];
            q_question[j] = q_question[j+1];
            q_ticket[j] = q_ticket[j+1];
        end
        q_fill--;
        q_visited++;
    endtask

    function automatic int find_key(input logic [31:0] key);
        for (int i = 0; i < q_fill; i++)
            if (q_key[i] == key) return i;
        return -1;
    endfunction

    // queue behavior for one accepted command
    task automatic predict_command(input logic [71:0] d);
        logic [2:0]  act;
        logic [31:0] key;
        logic [3:0]  topic;
        logic [31:0] qw;
        logic        fail;
        int          pos;
        int          n;
        int          i;
        t_result     r;
        act = d[2:0];
        key = d[34:3];
        topic = d[38:35];
        qw = d[70:39];
        fail = 1'b1;
        n = 0;
        case (act)
            ACT_PUSH: begin
                if (qw != MinusOneWord && q_fill < Depth) begin
                    q_key[q_fill] = key;
                    q_topic[q_fill] = topic;
                    q_question[q_fill] = qw;
                    q_ticket[q_fill] = q_visited + 16'(q_fill);
                    q_fill++;
                    q_done = (q_visited == Depth);
                    fail = 1'b0;
                end
            end
            ACT_POP: begin
                if (q_fill > 0) begin
                    drop_entry(0);
                    q_done = (q_fill == 0);
                    fail = 1'b0;
                end
            end
            ACT_REM_KEY: begin
                pos = find_key(key);
                if (pos >= 0) begin
                    drop_entry(pos);
                    q_done = (q_visited == Depth);
                    fail = 1'b0;
                end
            end
            ACT_REM_TOPIC: begin
                i = 0;
                while (i < q_fill) begin
                    if (q_topic[i] == topic && q_question[i] == qw) begin
                        drop_entry(i);
                        fail = 1'b0;
                    end else begin
                        i++;
                    end
                end
                if (!fail) q_done = (q_visited == Depth);
            end
            ACT_UPD_KEY: begin
                pos = find_key(key);
                if (pos >= 0) begin
                    q_topic[pos] = topic;
                    q_question[pos] = qw;
                    fail = 1'b0;
                end
            end
            ACT_GROUP: begin
                for (i = 0; i < q_fill && n < ResultLimit; i++) begin
                    if (q_topic[i] == topic && q_question[i] == qw) begin
                        expected_results.push_back(
                            make_result(1'b0, q_key[i], q_ticket[i], i, 1'b0));
                        n++;
                    end
                end
                if (n > 0) begin
                    r = expected_results.pop_back();
                    r.last = 1'b1;
                    expected_results.push_back(r);
                    o_group_hits += n;
                end
            end
            default: ;
        endcase
        if (n == 0) expected_results.push_back(make_result(fail, '0, '0, 0, 1'b1));
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            q_fill = 0;
            q_visited = '0;
            q_done = 1'b0;
            expected_results.delete();
            o_fail_count = 0;
            o_result_count = 0;
            o_group_hits = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", {3'b0, i_out_last, i_out_data[59:0]}, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data[0] !== want.data[0])
                        report_mismatch("status", i_out_data[0], want.data[0]);
                    if (i_out_data[32:1] !== want.data[32:1])
                        report_mismatch("entry_key", i_out_data[32:1], want.data[32:1]);
                    if (i_out_data[48:33] !== want.data[48:33])
                        report_mismatch("entry_ticket", i_out_data[48:33], want.data[48:33]);
                    if (i_out_data[53:49] !== want.data[53:49])
                        report_mismatch("match_index", i_out_data[53:49], want.data[53:49]);
                    if (i_out_data[58:54] !== want.data[58:54])
                        report_mismatch("occupancy", i_out_data[58:54], want.data[58:54]);
                    if (i_out_data[59] !== want.data[59])
                        report_mismatch("completed", i_out_data[59], want.data[59]);
                    if (i_out_last !== want.last)
                        report_mismatch("last", i_out_last, want.last);
                end
            end
            if (i_in_valid && i_in_ready) predict_command(i_in_data);
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- test/tb_top.sv -----
// testbench top for the match-delete queue: stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import fqmd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [71:0] in_data;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] out_data;
    logic        out_last;
    int          fail_count;
    int          pending;
    int          result_count;
    int          group_hits;
    int          sent_count;
    bit          hold_off;

    // small pools so matches are common
    logic [31:0] key_pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_5A5A};
    logic [31:0] qw_pool [3] = '{32'h3F80_0000, 32'h0, 32'hFFFF_FFFF};

    fifo_queue_with_match_delete u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(in_valid),
        .s_axis_tready(in_ready),
        .s_axis_tdata (in_data),
        .m_axis_tvalid(out_valid),
        .m_axis_tready(out_ready),
        .m_axis_tdata (out_data),
        .m_axis_tlast (out_last)
    );

    fqmd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_out_last    (out_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count),
        .o_group_hits  (group_hits)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 1);
        return $urandom_range(2, 12);
    endfunction

    // send one item and wait for acceptance
    task automatic send_item(input logic [2:0] act, input logic [31:0] key,
                             input logic [3:0] topic, input logic [31:0] qw, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        repeat (g) @(negedge i_clk);
        in_data = {1'b0, qw, topic, key, act};
        in_valid = 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic random_item(input bit well_formed);
        logic [2:0]  act;
        logic [31:0] key;
        logic [31:0] qw;
        logic [3:0]  topic;
        if (well_formed) begin
            act = ($urandom_range(0, 2) == 0) ? ACT_PUSH : 3'($urandom_range(0, 5));
            key = key_pool[$urandom_range(0, 3)];
            qw = qw_pool[$urandom_range(0, 2)];
            topic = 4'($urandom_range(0, 2) * 7);
        end else begin
            act = 3'($urandom);
            key = $urandom;
            qw = ($urandom_range(0, 5) == 0) ? MinusOneWord : $urandom;
            topic = 4'($urandom);
        end
        send_item(act, key, topic, qw, 1'b1);
    endtask

    // receiver: random stalls, and one long hold-off on request
    initial begin
        out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_off = 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(3, 20)) @(negedge i_clk);
            end else begin
                out_ready <= ($urandom_range(0, 9) < 7)
                             || (sent_count > 120 && sent_count < 180);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int drain_wait;
        in_valid = 1'b0;
        in_data = '0;
        hold_off = 1'b0;
        sent_count = 0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty-queue failures, minus one push, undefined actions, fill, group, update, deletes
        send_item(ACT_POP, 0, 4'h0, 0, 1'b0);
        send_item(ACT_REM_KEY, 32'hFFFF_FFFF, 4'hF, 0, 1'b0);
        send_item(ACT_UPD_KEY, 0, 4'h0, 0, 1'b0);
        send_item(ACT_GROUP, 0, 4'h0, 0, 1'b0);
        send_item(ACT_PUSH, 1, 4'hF, MinusOneWord, 1'b0);
        send_item(3'd6, 0, 4'h0, 0, 1'b0);
        send_item(3'd7, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 1'b0);
        for (int i = 0; i < 17; i++)
            send_item(ACT_PUSH, (i == 0) ? 32'hFFFF_FFFF : i, (i < 15) ? 4'hF : 4'h0,
                      (i < 15) ? 32'hFFFF_FFFF : 32'h0, 1'b0);
        send_item(ACT_GROUP, 0, 4'hF, 32'hFFFF_FFFF, 1'b0);
        send_item(ACT_UPD_KEY, 3, 4'h0, 32'h0, 1'b0);
        send_item(ACT_REM_KEY, 32'hFFFF_FFFF, 4'h0, 0, 1'b0);
        send_item(ACT_REM_TOPIC, 0, 4'hF, 32'hFFFF_FFFF, 1'b0);
        send_item(ACT_GROUP, 0, 4'h0, 32'h0, 1'b0);
        send_item(ACT_POP, 0, 4'h0, 0, 1'b0);
        wait_drained();

        // random, with a long receiver hold-off early on
        for (int n = 0; n < 350; n++) begin
            if (n == 40) hold_off = 1'b1;
            if (n == 200) wait_drained();
            random_item($urandom_range(0, 9) < 8);
        end

        wait_drained();
        drain_wait = 0;
        while (drain_wait < 50) begin
            @(negedge i_clk);
            drain_wait++;
        end
        $display("sent %0d items, checked %0d result items, %0d group matches",
                 sent_count, result_count, group_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/fqmd_pkg.sv
hdl/fqmd_cell.sv
hdl/fifo_queue_with_match_delete.sv
test/fqmd_checker.sv
test/tb_top.sv
